// ----- rtl/cde_pkg.sv -----
// Shared types, constants and helper functions of the cone distance estimate unit.
package cde_pkg;

    localparam int FRAC_BITS = 16;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_RADIUS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONE_HEIGHT = 3'd4;

    localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

    // Square root pipeline: one result bit per stage.
    localparam int SQ_OUT_W = 34;
    localparam int SQ_IN_W  = 2 * SQ_OUT_W;
    localparam int SQ_REM_W = SQ_OUT_W + 3;

    // Restoring divider: one quotient bit per stage.
    localparam int DIV_Q_W = 31;
    localparam int DIV_A_W = 66;
    localparam int DIV_B_W = 32;

    // Delay that lines the quotient up with the second root.
    localparam int QD_N = SQ_OUT_W - DIV_Q_W;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] direction_y;
    } t_cde_in;

    typedef struct packed {
        logic [30:0] distance;
        logic        no_hit;
    } t_cde_out;

    function automatic logic [32:0] cde_mag(input logic signed [32:0] v);
        logic [32:0] res;
        res = v[32] ? 33'(-v) : 33'(v);
        return res;
    endfunction

    function automatic logic [30:0] cde_sat(input logic [SQ_OUT_W-1:0] v);
        logic [30:0] res;
        res = (v > {3'b000, DIST_MAX}) ? DIST_MAX : v[30:0];
        return res;
    endfunction

endpackage

// ----- rtl/cde_sqrt.sv -----
// Pipelined floor square root, one result bit resolved per register stage.
module cde_sqrt (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [cde_pkg::SQ_IN_W-1:0]  i_rad,
    output logic [cde_pkg::SQ_OUT_W-1:0] o_root
);
    import cde_pkg::*;

    logic [SQ_IN_W-1:0]  r_x    [SQ_OUT_W];
    logic [SQ_REM_W-1:0] r_rem  [SQ_OUT_W];
    logic [SQ_OUT_W-1:0] r_root [SQ_OUT_W];
    logic [SQ_IN_W-1:0]  n_x    [SQ_OUT_W];
    logic [SQ_REM_W-1:0] n_rem  [SQ_OUT_W];
    logic [SQ_OUT_W-1:0] n_root [SQ_OUT_W];

    for (genvar j = 0; j < SQ_OUT_W; j++) begin : g_stage
        logic [SQ_IN_W-1:0]  p_x;
        logic [SQ_REM_W-1:0] p_rem;
        logic [SQ_OUT_W-1:0] p_root;
        logic [SQ_REM_W-1:0] c_rem;
        logic [SQ_REM_W-1:0] c_trial;

        if (j == 0) begin : g_first
            assign p_x    = i_rad;
            assign p_rem  = '0;
            assign p_root = '0;
        end else begin : g_next
            assign p_x    = r_x[j-1];
            assign p_rem  = r_rem[j-1];
            assign p_root = r_root[j-1];
        end

        // Bring down the next two radicand bits and try the next root bit.
        assign c_rem   = {p_rem[SQ_REM_W-3:0], p_x[SQ_IN_W-1 -: 2]};
        assign c_trial = {1'b0, p_root, 2'b01};
        assign n_x[j]  = p_x << 2;

        always_comb begin
            if (c_rem >= c_trial) begin
                n_rem[j]  = c_rem - c_trial;
                n_root[j] = {p_root[SQ_OUT_W-2:0], 1'b1};
            end else begin
                n_rem[j]  = c_rem;
                n_root[j] = {p_root[SQ_OUT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < SQ_OUT_W; j++) begin
                r_x[j]    <= n_x[j];
                r_rem[j]  <= n_rem[j];
                r_root[j] <= n_root[j];
            end
        end
    end

    assign o_root = r_root[SQ_OUT_W-1];

endmodule

// ----- rtl/cde_div.sv -----
// Pipelined restoring divider, one quotient bit resolved per register stage.
module cde_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [cde_pkg::DIV_A_W-1:0] i_num,
    input  logic [cde_pkg::DIV_B_W-1:0] i_den,
    output logic [cde_pkg::DIV_Q_W-1:0] o_quot
);
    import cde_pkg::*;

    logic [DIV_A_W-1:0] r_rem [DIV_Q_W];
    logic [DIV_B_W-1:0] r_den [DIV_Q_W];
    logic [DIV_Q_W-1:0] r_q   [DIV_Q_W];
    logic [DIV_A_W-1:0] n_rem [DIV_Q_W];
    logic [DIV_Q_W-1:0] n_q   [DIV_Q_W];
    logic [DIV_B_W-1:0] n_den [DIV_Q_W];

    for (genvar k = 0; k < DIV_Q_W; k++) begin : g_stage
        logic [DIV_A_W-1:0] p_rem;
        logic [DIV_B_W-1:0] p_den;
        logic [DIV_Q_W-1:0] p_q;
        logic [DIV_A_W-1:0] c_sh;
        logic               c_ge;

        if (k == 0) begin : g_first
            assign p_rem = i_num;
            assign p_den = i_den;
            assign p_q   = '0;
        end else begin : g_next
            assign p_rem = r_rem[k-1];
            assign p_den = r_den[k-1];
            assign p_q   = r_q[k-1];
        end

        assign c_sh     = DIV_A_W'(p_den) << (DIV_Q_W - 1 - k);
        assign c_ge     = (p_rem >= c_sh);
        assign n_rem[k] = c_ge ? (p_rem - c_sh) : p_rem;
        assign n_q[k]   = {p_q[DIV_Q_W-2:0], c_ge};
        assign n_den[k] = p_den;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_Q_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= n_den[k];
                r_q[k]   <= n_q[k];
            end
        end
    end

    assign o_quot = r_q[DIV_Q_W-1];

endmodule

// ----- rtl/cone_distance_estimate_unit.sv -----
// Top level of the cone distance estimate unit: config registers and the query pipeline.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      i_in_valid / o_in_ready   i_in_data  (t_cde_in)
//   out       output     o_out_valid / i_out_ready o_out_data (t_cde_out)
//   cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// A query passes 73 register stages: two 34-stage square root pipelines in series
// (with the 31-stage divider running beside the second one) plus five arithmetic
// stages. The first stage loads at the input transfer edge; the result then shows on
// the output register once the query has passed through every stage.
// One query can enter every cycle. The whole pipeline advances together; it
// holds only while a finished result waits in the output register.
// Reset is synchronous and active low; it empties the pipeline and loads the
// configuration defaults (centered at the origin, unit radius and height).
module cone_distance_estimate_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  cde_pkg::t_cde_in                i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output cde_pkg::t_cde_out               o_out_data,
    input  logic                            i_cfg_we,
    input  logic [cde_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);
    import cde_pkg::*;

    // Sideband that rides beside the first pair of square roots.
    typedef struct packed {
        logic signed [32:0] dy;
        logic               no_hit;
    } t_side_a;

    // Sideband that rides beside the second square root and the divider.
    typedef struct packed {
        logic        no_hit;
        logic        in_radius;
        logic        neg;
        logic [32:0] dy_abs;
        logic        sat_q;
    } t_side_b;

    // Configuration registers.
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [30:0]        r_rad, r_hgt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_cz  <= '0;
            r_rad <= 31'd65536;
            r_hgt <= 31'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CENTER_X:    r_cx  <= i_cfg_data;
                CFG_CENTER_Y:    r_cy  <= i_cfg_data;
                CFG_CENTER_Z:    r_cz  <= i_cfg_data;
                CFG_BASE_RADIUS: r_rad <= i_cfg_data[30:0];
                CFG_CONE_HEIGHT: r_hgt <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves as one unless a result is stuck in the output register.
    logic w_en;
    logic r_out_valid;
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // Stage 0: offsets from the base center and the no-hit test.
    logic signed [32:0] n0_dx, n0_dy, n0_dz;
    logic               n0_no_hit;
    logic               r0_v;
    logic signed [32:0] r0_dx, r0_dy, r0_dz;
    logic               r0_no_hit;

    always_comb begin
        n0_dx = $signed({i_in_data.origin_x[31], i_in_data.origin_x}) - $signed({r_cx[31], r_cx});
        n0_dy = $signed({i_in_data.origin_y[31], i_in_data.origin_y}) - $signed({r_cy[31], r_cy});
        n0_dz = $signed({i_in_data.origin_z[31], i_in_data.origin_z}) - $signed({r_cz[31], r_cz});
        // A zero direction counts as heading away in both cases.
        n0_no_hit = (n0_dy[32] && (i_in_data.direction_y[31] || (i_in_data.direction_y == 32'sd0)))
                 || ((n0_dy > $signed({2'b00, r_hgt})) && !i_in_data.direction_y[31]);
    end

    // Stage 1: squares for the radial distance and the slant length.
    logic               r1_v;
    logic [65:0]        r1_sxx, r1_szz;
    logic [61:0]        r1_rr, r1_hh;
    logic signed [32:0] r1_dy;
    logic               r1_no_hit;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_dx     <= n0_dx;
            r0_dy     <= n0_dy;
            r0_dz     <= n0_dz;
            r0_no_hit <= n0_no_hit;
            r1_sxx    <= cde_mag(r0_dx) * cde_mag(r0_dx);
            r1_szz    <= cde_mag(r0_dz) * cde_mag(r0_dz);
            r1_rr     <= r_rad * r_rad;
            r1_hh     <= r_hgt * r_hgt;
            r1_dy     <= r0_dy;
            r1_no_hit <= r0_no_hit;
        end
    end

    // Radial distance r and slant length b, computed side by side.
    logic [SQ_OUT_W-1:0] w_root_r, w_root_b;

    cde_sqrt u_sqrt_r (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (SQ_IN_W'(r1_sxx) + SQ_IN_W'(r1_szz)),
        .o_root (w_root_r)
    );

    cde_sqrt u_sqrt_b (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (SQ_IN_W'(r1_rr) + SQ_IN_W'(r1_hh)),
        .o_root (w_root_b)
    );

    logic [SQ_OUT_W-1:0] r_va;
    t_side_a             r_sa [SQ_OUT_W];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sa[0] <= '{dy: r1_dy, no_hit: r1_no_hit};
            for (int j = 1; j < SQ_OUT_W; j++) begin
                r_sa[j] <= r_sa[j-1];
            end
        end
    end

    // Stage 3: products for the side line distance and the base disc terms.
    t_side_a     w_sa;
    logic [31:0] w_dy_pos;
    assign w_sa     = r_sa[SQ_OUT_W-1];
    assign w_dy_pos = w_sa.dy[32] ? 32'd0 : w_sa.dy[31:0];

    logic        r3_v;
    logic [62:0] r3_rdy;
    logic [63:0] r3_rh;
    logic [61:0] r3_q;
    logic        r3_inside;
    logic [32:0] r3_d;
    logic [32:0] r3_dy_abs;
    logic        r3_neg;
    logic [31:0] r3_b;
    logic        r3_no_hit;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_rdy    <= r_rad * w_dy_pos;
            r3_rh     <= w_root_r[32:0] * r_hgt;
            r3_q      <= r_rad * r_hgt;
            r3_inside <= (w_root_r < {3'b000, r_rad});
            r3_d      <= w_root_r[32:0] - {2'b00, r_rad};
            r3_dy_abs <= cde_mag(w_sa.dy);
            r3_neg    <= w_sa.dy[32];
            // Radius and height both zero would give a zero divisor.
            r3_b      <= (w_root_b == '0) ? 32'd1 : w_root_b[31:0];
            r3_no_hit <= w_sa.no_hit;
        end
    end

    // Stage 4: numerator of the side distance and the base disc squares.
    logic [DIV_A_W-1:0] w_p, w_q;
    assign w_p = DIV_A_W'(r3_rdy) + DIV_A_W'(r3_rh);
    assign w_q = DIV_A_W'(r3_q);

    logic               r4_v;
    logic [DIV_A_W-1:0] r4_a;
    logic [65:0]        r4_dd, r4_yy;
    logic [31:0]        r4_b;
    logic               r4_inside, r4_neg, r4_no_hit;
    logic [32:0]        r4_dy_abs;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_a      <= (w_p >= w_q) ? (w_p - w_q) : (w_q - w_p);
            r4_dd     <= r3_d * r3_d;
            r4_yy     <= r3_dy_abs * r3_dy_abs;
            r4_b      <= r3_b;
            r4_inside <= r3_inside;
            r4_neg    <= r3_neg;
            r4_no_hit <= r3_no_hit;
            r4_dy_abs <= r3_dy_abs;
        end
    end

    // Distance to the disc edge and the side distance quotient.
    logic [SQ_OUT_W-1:0] w_root_e;
    logic [DIV_Q_W-1:0]  w_quot;

    cde_sqrt u_sqrt_e (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (SQ_IN_W'(r4_dd) + SQ_IN_W'(r4_yy)),
        .o_root (w_root_e)
    );

    cde_div u_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r4_a),
        .i_den  (r4_b),
        .o_quot (w_quot)
    );

    logic [SQ_OUT_W-1:0] r_vb;
    t_side_b             r_sb [SQ_OUT_W];
    logic [DIV_Q_W-1:0]  r_qd [QD_N];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // A quotient that would not fit in 31 bits saturates.
            r_sb[0] <= '{no_hit: r4_no_hit, in_radius: r4_inside, neg: r4_neg,
                         dy_abs: r4_dy_abs,
                         sat_q: ((DIV_A_W'(r4_b) << DIV_Q_W) <= r4_a)};
            for (int j = 1; j < SQ_OUT_W; j++) begin
                r_sb[j] <= r_sb[j-1];
            end
            r_qd[0] <= w_quot;
            for (int j = 1; j < QD_N; j++) begin
                r_qd[j] <= r_qd[j-1];
            end
        end
    end

    // Final stage: pick the distance for the region the origin is in.
    t_side_b     w_sb;
    logic [30:0] w_side, w_gap;
    t_cde_out    n_out_data;
    t_cde_out    r_out_data;
    assign w_sb   = r_sb[SQ_OUT_W-1];
    assign w_side = w_sb.sat_q ? DIST_MAX : r_qd[QD_N-1];
    assign w_gap  = cde_sat({1'b0, w_sb.dy_abs});

    always_comb begin
        n_out_data.no_hit = w_sb.no_hit;
        if (w_sb.no_hit) begin
            n_out_data.distance = '0;
        end else if (w_sb.neg) begin
            n_out_data.distance = w_sb.in_radius ? w_gap : cde_sat(w_root_e);
        end else begin
            n_out_data.distance = (w_sb.in_radius && (w_gap < w_side)) ? w_gap : w_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
        end
    end

    // Valid bits of every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v        <= 1'b0;
            r1_v        <= 1'b0;
            r_va        <= '0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            r_vb        <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r0_v        <= i_in_valid;
            r1_v        <= r0_v;
            r_va        <= {r_va[SQ_OUT_W-2:0], r1_v};
            r3_v        <= r_va[SQ_OUT_W-1];
            r4_v        <= r3_v;
            r_vb        <= {r_vb[SQ_OUT_W-2:0], r4_v};
            r_out_valid <= r_vb[SQ_OUT_W-1];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A no-hit result always reports a zero distance.
    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.no_hit) |-> (o_out_data.distance == '0))
        else $error("no-hit result with nonzero distance");

    // The pipeline comes out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_out_valid && !r0_v && (r_vb == '0)))
        else $error("pipeline not empty after reset");

    // With nothing waiting at the output, a new query is always taken.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    // A result shows at the output only if the last stage held a query when the pipeline advanced.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && !r_vb[SQ_OUT_W-1]) |=> !o_out_valid)
        else $error("result appeared without a query behind it");

endmodule
